>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ALD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ALD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ald_pkg.sv
// Package with widths, register indexes and constants of the light dimmer.
`timescale 1ns / 1ps

package ald_pkg;

   localparam int LIGHT_W          = 10;
   localparam int INTENSITY_W      = 9;
   localparam int TDATA_W          = 16;
   localparam int CSR_DATA_W       = 16;
   localparam int CSR_INDEX_W      = 3;
   localparam int ADC_BITS_DEFAULT = 10;

   localparam int PCT_W            = 7;
   localparam int INTERVAL_W       = 16;
   localparam int CLAMP_W          = 9;
   localparam int SHIFT_W          = 4;
   localparam int SUM_W            = 17;

   localparam int DIV_W            = 18;
   localparam int QUOT_W           = 9;

   // reciprocals: x/255 = x*RECIP_ADC >> 25 for x < 2^17,
   // x/400 = (x>>4)*RECIP_FS >> 19 for x < 2^18
   localparam int RECIP_W          = 18;
   localparam int RECIP_ADC        = 131587;
   localparam int RECIP_ADC_SHIFT  = 25;
   localparam int RECIP_FS         = 20972;
   localparam int RECIP_FS_SHIFT   = 19;
   localparam int FS_PRESHIFT      = 4;

   localparam int FULL_SCALE       = 400;
   localparam int ADC_FULL         = 255;
   localparam int PCT_MAX          = 100;
   localparam int SHIFT_MAX        = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MIN_PERCENT     = 3'd0,
      REG_MAX_PERCENT     = 3'd1,
      REG_UPDATE_INTERVAL = 3'd2,
      REG_CLAMP_HIGH      = 3'd3,
      REG_CLAMP_LOW       = 3'd4,
      REG_FILTER_SHIFT    = 3'd5
   } reg_index_type;

endpackage

>>> hw/rtl/ald_divider.sv
// Shared divider by 255 or 400 using registered reciprocal multiplication.
`timescale 1ns / 1ps

module ald_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ald_pkg::DIV_W-1:0]    dividend,
   input  logic                         by_full_scale,
   output logic                         done,
   output logic [ald_pkg::QUOT_W-1:0]   quotient
);

   localparam int DivW   = ald_pkg::DIV_W;
   localparam int QuotW  = ald_pkg::QUOT_W;
   localparam int RecipW = ald_pkg::RECIP_W;
   localparam int ProdW  = DivW + RecipW;

   logic              pend_ff, pend_in;
   logic              done_ff, done_in;
   logic [DivW-1:0]   num_ff, num_in;
   logic              sel_ff, sel_in;
   logic [QuotW-1:0]  quot_ff, quot_in;
   logic [DivW-1:0]   mul_a;
   logic [RecipW-1:0] mul_b;
   logic [ProdW-1:0]  product;

   assign mul_a   = sel_ff ? (num_ff >> ald_pkg::FS_PRESHIFT) : num_ff;
   assign mul_b   = sel_ff ? RecipW'(ald_pkg::RECIP_FS) : RecipW'(ald_pkg::RECIP_ADC);
   assign product = ProdW'(mul_a) * ProdW'(mul_b);

   always_comb begin
      pend_in = start;
      done_in = pend_ff;
      num_in  = start ? dividend : num_ff;
      sel_in  = start ? by_full_scale : sel_ff;
      quot_in = quot_ff;
      if (pend_ff) begin
         quot_in = sel_ff ? product[ald_pkg::RECIP_FS_SHIFT +: QuotW] :
                            product[ald_pkg::RECIP_ADC_SHIFT +: QuotW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      sel_ff  <= sel_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> hw/rtl/ambient_light_dimmer.sv
// Top level: ambient light sample to filtered PWM intensity; a skipped tick only counts.
// An update tick walks DIV1, MAP, DIV2, CLAMP, FILT and OUT before rsp_tvalid rises:
// two passes of the shared divider with the MAP step between, then clamp, filter and output.
// req_tready and csr_ready stay low during the update, and a result still waiting
// in the output register holds the update in its last step.
// Synchronous reset restores register defaults and clears counter and filter.
`timescale 1ns / 1ps

module ambient_light_dimmer #(
   parameter int ADC_BITS = ald_pkg::ADC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ald_pkg::TDATA_W-1:0]       req_tdata,   // [9:0] light_sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ald_pkg::TDATA_W-1:0]       rsp_tdata,   // [8:0] intensity
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ald_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ald_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int LightW = ald_pkg::LIGHT_W;
   localparam int DivW   = ald_pkg::DIV_W;
   localparam int QuotW  = ald_pkg::QUOT_W;
   localparam int SumW   = ald_pkg::SUM_W;
   localparam int ClampW = ald_pkg::CLAMP_W;
   localparam int PctW   = ald_pkg::PCT_W;
   localparam int ShW    = ald_pkg::SHIFT_W;
   localparam int IntW   = ald_pkg::INTERVAL_W;
   localparam int OutW   = ald_pkg::INTENSITY_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV1,
      S_MAP,
      S_DIV2,
      S_CLAMP,
      S_FILT,
      S_OUT
   } state_type;

   // configuration
   logic [PctW-1:0]   min_pct_ff;
   logic [PctW-1:0]   max_pct_ff;
   logic [IntW-1:0]   interval_ff;
   logic [ClampW-1:0] clamp_hi_ff;
   logic [ClampW-1:0] clamp_lo_ff;
   logic [ShW-1:0]    shift_cfg_ff;

   state_type         state_ff, state_in;
   logic [IntW-1:0]   tick_ff, tick_in;
   logic [SumW-1:0]   sum_ff, sum_in;
   logic [ClampW-1:0] vmin_ff, vmin_in;
   logic [ClampW-1:0] span_ff, span_in;
   logic [ShW-1:0]    sh_ff, sh_in;
   logic [ClampW-1:0] mapped_ff, mapped_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OutW-1:0]   rsp_data_ff, rsp_data_in;

   logic                       req_fire;
   logic [LightW+ADC_BITS-1:0] sample_wide;
   logic [ADC_BITS-1:0]        sample;
   logic [7:0]                 inv8;
   logic [PctW-1:0]            min_sat, max_sat;
   logic [ClampW-1:0]          vmin_c, vmax_c;
   logic [ClampW-1:0]          hi_sat, lo_sat, mapped_c;
   logic [SumW-1:0]            dec;
   logic [SumW:0]              next_sum;
   logic [SumW-1:0]            shifted;

   logic                       div_start, div_done, div_by_fs;
   logic [DivW-1:0]            div_dividend;
   logic [QuotW-1:0]           div_quot;

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = state_ff == S_IDLE;

   assign sample_wide = {ADC_BITS'(0), req_tdata[LightW-1:0]};
   assign sample      = sample_wide[ADC_BITS-1:0];
   assign inv8        = ~sample[ADC_BITS-1 -: 8];

   assign min_sat = (min_pct_ff > PctW'(ald_pkg::PCT_MAX)) ?
                    PctW'(ald_pkg::PCT_MAX) : min_pct_ff;
   assign max_sat = (max_pct_ff > PctW'(ald_pkg::PCT_MAX)) ?
                    PctW'(ald_pkg::PCT_MAX) : max_pct_ff;
   assign vmin_c  = {min_sat, 2'b00};
   assign vmax_c  = {max_sat, 2'b00};

   assign hi_sat = (clamp_hi_ff > ClampW'(ald_pkg::FULL_SCALE)) ?
                   ClampW'(ald_pkg::FULL_SCALE) : clamp_hi_ff;
   assign lo_sat = (clamp_lo_ff > ClampW'(ald_pkg::FULL_SCALE)) ?
                   ClampW'(ald_pkg::FULL_SCALE) : clamp_lo_ff;
   assign mapped_c = vmin_ff + div_quot;

   assign dec      = sum_ff >> sh_ff;
   assign next_sum = {1'b0, sum_ff - dec} + (SumW+1)'(mapped_ff);
   assign shifted  = sum_ff >> sh_ff;

   // shared divider: level = inv*400/255, then span*level/400
   always_comb begin
      div_start    = 1'b0;
      div_by_fs    = 1'b0;
      div_dividend = DivW'(inv8) * DivW'(ald_pkg::FULL_SCALE);
      if (state_ff == S_MAP) begin
         div_start    = 1'b1;
         div_by_fs    = 1'b1;
         div_dividend = DivW'(span_ff) * DivW'(div_quot);
      end else if (req_fire && tick_ff >= interval_ff) begin
         div_start = 1'b1;
      end
   end

   ald_divider u_divider (
      .clock         (clock),
      .reset         (reset),
      .start         (div_start),
      .dividend      (div_dividend),
      .by_full_scale (div_by_fs),
      .done          (div_done),
      .quotient      (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      sum_in       = sum_ff;
      vmin_in      = vmin_ff;
      span_in      = span_ff;
      sh_in        = sh_ff;
      mapped_in    = mapped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (tick_ff < interval_ff) begin
                  tick_in = tick_ff + 1'b1;
               end else begin
                  tick_in  = '0;
                  vmin_in  = vmin_c;
                  span_in  = (vmax_c > vmin_c) ? vmax_c - vmin_c : '0;
                  sh_in    = (shift_cfg_ff > ShW'(ald_pkg::SHIFT_MAX)) ?
                             ShW'(ald_pkg::SHIFT_MAX) : shift_cfg_ff;
                  state_in = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            if (div_done) begin
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            state_in = S_DIV2;
         end
         S_DIV2: begin
            if (div_done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            priority if (mapped_c > hi_sat) begin
               mapped_in = hi_sat;
            end else if (mapped_c < lo_sat) begin
               mapped_in = lo_sat;
            end else begin
               mapped_in = mapped_c;
            end
            state_in = S_FILT;
         end
         S_FILT: begin
            sum_in   = next_sum[SumW] ? '1 : next_sum[SumW-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = shifted[OutW-1:0];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vmin_ff     <= vmin_in;
      span_ff     <= span_in;
      sh_ff       <= sh_in;
      mapped_ff   <= mapped_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pct_ff   <= PctW'(1);
         max_pct_ff   <= PctW'(100);
         interval_ff  <= IntW'(100);
         clamp_hi_ff  <= ClampW'(400);
         clamp_lo_ff  <= '0;
         shift_cfg_ff <= ShW'(3);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ald_pkg::REG_MIN_PERCENT:     min_pct_ff   <= csr_data[PctW-1:0];
            ald_pkg::REG_MAX_PERCENT:     max_pct_ff   <= csr_data[PctW-1:0];
            ald_pkg::REG_UPDATE_INTERVAL: interval_ff  <= csr_data[IntW-1:0];
            ald_pkg::REG_CLAMP_HIGH:      clamp_hi_ff  <= csr_data[ClampW-1:0];
            ald_pkg::REG_CLAMP_LOW:       clamp_lo_ff  <= csr_data[ClampW-1:0];
            ald_pkg::REG_FILTER_SHIFT:    shift_cfg_ff <= csr_data[ShW-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ald_pkg::TDATA_W-OutW){1'b0}}, rsp_data_ff};

endmodule

>>> hw/rtl/ald_checker.sv
// Port-level checker for the light dimmer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ald_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ald_pkg::TDATA_W-1:0]     rsp_tdata
);

   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty

   property p_result_after_busy;
      $rose(rsp_tvalid) |-> $past(!req_tready);
   endproperty

   property p_update_multicycle;
      $fell(req_tready) |=> !req_tready;
   endproperty

   property p_rsp_pad;
      rsp_tdata[ald_pkg::TDATA_W-1:ald_pkg::INTENSITY_W] == '0;
   endproperty

   `ALD_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "result changed while stalled")
   `ALD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `ALD_ASSERT(a_result_after_busy, clock, reset, p_result_after_busy, "result without update")
   `ALD_ASSERT(a_update_multicycle, clock, reset, p_update_multicycle, "update too short")
   `ALD_ASSERT(a_rsp_pad, clock, reset, p_rsp_pad, "result padding bits set")

endmodule

bind ambient_light_dimmer ald_checker u_ald_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
